// ===== rtl/update_index_ring_with_overflow_core_macros.svh =====
// assertion macros for the update index ring
`ifndef UPDATE_INDEX_RING_WITH_OVERFLOW_CORE_MACROS_SVH
`define UPDATE_INDEX_RING_WITH_OVERFLOW_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define UIRO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define UIRO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define UIRO_ASSERT(lbl, clk, rst_n, prop, msg)
`define UIRO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/uiro_pkg.sv =====
package uiro_pkg;

	localparam int IDX_W   = 10;
	localparam int PROBE_W = 6;
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_VALID    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

	localparam logic OP_MARK  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture input word
		logic home;   // reduce item index to home slot
		logic rot;    // build rotated probe window
		logic pick;   // claim first free slot or flag overflow
		logic fetch;  // pop lowest used slot
		logic out;    // load output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ovf;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/uiro_ctrl.sv =====
module uiro_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tuser,
	output logic            s_tready,
	input  uiro_pkg::sts_t  sts,
	output uiro_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HOME  = 3'd1;
	localparam logic [2:0] ST_ROT   = 3'd2;
	localparam logic [2:0] ST_PICK  = 3'd3;
	localparam logic [2:0] ST_FETCH = 3'd4;
	localparam logic [2:0] ST_FOUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.load  = acc;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					// a mark while overflow is pending leaves the slot flags and the overflow flag as they are
					if (s_tuser == uiro_pkg::OP_FETCH)
						state_d = ST_FETCH;
					else if (!sts.ovf)
						state_d = ST_HOME;
				end
			end
			ST_HOME: begin
				cmd.home = 1'b1;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot = 1'b1;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_FOUT;
			end
			ST_FOUT: begin
				if (sts.out_free) begin
					cmd.out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/uiro_dp.sv =====
module uiro_dp #(
	parameter int SLOTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  uiro_pkg::cmd_t                       cmd,
	output uiro_pkg::sts_t                       sts,
	input  logic [uiro_pkg::IDX_W-1:0]           in_item,
	input  logic [uiro_pkg::PROBE_W-1:0]         in_extra,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [uiro_pkg::KIND_W-1:0]          out_kind,
	output logic [uiro_pkg::IDX_W-1:0]           out_index
);

	localparam int IW    = uiro_pkg::IDX_W;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RECIP = (2 ** IW) / SLOTS;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = IW + RW;
	localparam int QW    = IW + RW;

	localparam logic [IW:0] SLOTS_X = (IW + 1)'(SLOTS);
	localparam logic [SW:0] SLOTS_S = (SW + 1)'(SLOTS);

	logic [IW-1:0]               item_q;
	logic [uiro_pkg::PROBE_W-1:0] extra_q;
	logic [RW-1:0]               quot_q;
	logic [SW-1:0]               home_q;
	logic [SLOTS-1:0]            rot_q;
	logic [SLOTS-1:0]            used_q;
	logic                        ovf_q;
	logic [uiro_pkg::KIND_W-1:0] kind_q;
	logic [IW-1:0]               rd_q;
	logic [IW-1:0]               mem [SLOTS];

	logic [PW-1:0]      prod;
	logic [QW-1:0]      qs_full;
	logic [IW:0]        rem;
	logic [IW:0]        rem_fix;
	logic [2*SLOTS-1:0] free_dbl;
	logic [2*SLOTS-1:0] free_sh;
	logic [SLOTS-1:0]   win;
	logic [SW-1:0]      probe_off;
	logic               found;
	logic [SW:0]        pos_sum;
	logic [SW-1:0]      pos;
	logic [SW-1:0]      fidx;
	logic               any_used;

	// quotient estimate by reciprocal, low by at most one
	assign prod = {{RW{1'b0}}, in_item} * PW'(RECIP);

	// remainder, then one correcting subtract
	assign qs_full = {{IW{1'b0}}, quot_q} * QW'(SLOTS);
	assign rem     = {1'b0, item_q} - {1'b0, qs_full[IW-1:0]};
	assign rem_fix = (rem >= SLOTS_X) ? (rem - SLOTS_X) : rem;

	// free slots seen from the home slot upward, with wrap
	assign free_dbl = {~used_q, ~used_q};
	assign free_sh  = free_dbl >> home_q;

	always_comb begin
		for (int j = 0; j < SLOTS; j++)
			win[j] = (32'(j) <= 32'(extra_q));
	end

	always_comb begin
		probe_off = '0;
		found     = 1'b0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (rot_q[j]) begin
				probe_off = SW'(j);
				found     = 1'b1;
			end
		end
	end

	assign pos_sum = {1'b0, home_q} + {1'b0, probe_off};
	always_comb begin
		if (pos_sum >= SLOTS_S)
			pos = SW'(pos_sum - SLOTS_S);
		else
			pos = pos_sum[SW-1:0];
	end

	always_comb begin
		fidx     = '0;
		any_used = 1'b0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (used_q[j]) begin
				fidx     = SW'(j);
				any_used = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= in_item;
			extra_q <= in_extra;
			quot_q  <= prod[PW-1:IW];
		end
		if (cmd.home)
			home_q <= rem_fix[SW-1:0];
		if (cmd.rot)
			rot_q <= free_sh[SLOTS-1:0] & win;
		if (cmd.fetch) begin
			if (ovf_q)
				kind_q <= uiro_pkg::KIND_OVERFLOW;
			else if (any_used)
				kind_q <= uiro_pkg::KIND_VALID;
			else
				kind_q <= uiro_pkg::KIND_NONE;
		end
		if (cmd.out) begin
			out_kind  <= kind_q;
			out_index <= (kind_q == uiro_pkg::KIND_VALID) ? rd_q : '0;
		end
	end

	// index store
	always_ff @(posedge clk) begin
		if (cmd.pick && found)
			mem[pos] <= item_q;
		if (cmd.fetch)
			rd_q <= mem[fidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.pick) begin
				if (found)
					used_q[pos] <= 1'b1;
				else
					ovf_q <= 1'b1;
			end
			if (cmd.fetch) begin
				if (ovf_q) begin
					used_q <= '0;
					ovf_q  <= 1'b0;
				end else if (any_used) begin
					used_q[fidx] <= 1'b0;
				end
			end
			if (cmd.out)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	assign sts.ovf      = ovf_q;
	assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/update_index_ring_with_overflow_core.sv =====
// update index ring: records which item indices changed in a ring of SLOTS slots.
// a mark word (tuser 0) probes from slot item_index mod SLOTS upward with wrap for
// extra_probes+1 slots and claims the first free one; with no free slot it raises
// the overflow flag, and with an overflow already pending it is dropped; it gives
// no result word. a fetch word (tuser 1) always gives one result: overflow (flag
// cleared, ring emptied, caller must rescan everything), the index held in the
// lowest used slot (slot freed), or no entries. a mark steps through accept with
// the reciprocal multiply, home-slot correction, rotated probe window, then
// priority pick and write; a mark that meets a pending overflow is dropped in its
// accept cycle. a fetch steps through accept, priority pick on the slot flags with
// the index store read, then output load, which waits for the result register.
// the index store has one registered read port, which sets the fetch length. the
// slot flags sit in flops and are cleared at reset, so there is no clearing pass.
// a new word is taken only when the previous one is done; a finished result may
// still wait in the output register while the next word is accepted.
`include "update_index_ring_with_overflow_core_macros.svh"

module update_index_ring_with_overflow_core #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] item_index, [15:10] extra_probes
	input  logic        s_tuser,   // [0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] result_index, [15:10] zero
	output logic [1:0]  m_tuser    // [1:0] result_kind
);

	uiro_pkg::cmd_t                 cmd;
	uiro_pkg::sts_t                 sts;
	logic [uiro_pkg::IDX_W-1:0]     out_index;

	// sequencer: one word in flight
	uiro_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot flags, index store, probe and pick logic, result register
	uiro_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (s_tdata[9:0]),
		.in_extra  (s_tdata[15:10]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_index (out_index)
	);

	// upper bits of the result word are padding
	assign m_tdata = {6'd0, out_index};

	// a fetch taken with the result register empty shows its result after the fetch and output-load states
	`UIRO_ASSERT(a_fetch_result, clk, arst_n,
		(s_tvalid && s_tready && s_tuser == uiro_pkg::OP_FETCH && !m_tvalid) |-> ##3 m_tvalid,
		"fetch did not produce a result word")

	// a mark never produces a result word
	`UIRO_ASSERT_NEXT(a_mark_silent, clk, arst_n,
		s_tvalid && s_tready && s_tuser == uiro_pkg::OP_MARK && !m_tvalid, !m_tvalid,
		"mark produced a result word")

	// only the three defined result kinds leave the block
	`UIRO_ASSERT(a_kind_legal, clk, arst_n,
		m_tvalid |-> (m_tuser == uiro_pkg::KIND_VALID || m_tuser == uiro_pkg::KIND_NONE ||
			m_tuser == uiro_pkg::KIND_OVERFLOW),
		"undefined result kind")

	// index is zero unless it is a valid index result
	`UIRO_ASSERT(a_index_zero, clk, arst_n,
		(m_tvalid && m_tuser != uiro_pkg::KIND_VALID) |-> (m_tdata == 16'd0),
		"non-zero index on a result without an index")

endmodule
